### src/min_heap_priority_queue_core_macros.svh
// assertion macros for the heap priority queue
`ifndef MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
`define MIN_HEAP_PRIORITY_QUEUE_CORE_MACROS_SVH
// check that a property holds after reset is released
`define MHPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MHPQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`endif

### src/mhpq_pkg.sv
// package for the heap priority queue: sizes, codes, state type
package mhpq_pkg;
    localparam int CAPACITY = 1024;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE,
        S_INS_WR,
        S_UP_RDP,
        S_UP_WAIT,
        S_UP_CMP,
        S_SRCH_RD,
        S_SRCH_WAIT,
        S_SRCH_CMP,
        S_RM_RDL,
        S_RM_WAITL,
        S_RM_WR,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_WAIT,
        S_DN_CMP,
        S_Q_RD,
        S_Q_WAIT,
        S_DONE
    } state_t;

    // datapath commands
    typedef struct packed {
        logic       load_in;
        logic       ins_write;
        logic       up_rd_parent;
        logic       up_swap;
        logic       srch_clear;
        logic       srch_rd;
        logic       srch_next;
        logic       rm_rd_last;
        logic       rm_write;
        logic       dn_rd_left;
        logic       dn_rd_right;
        logic       dn_latch_right;
        logic       dn_swap;
        logic       q_rd;
        logic       set_result;
        logic [1:0] result_status;
        logic       result_min;
        logic       result_empty;
    } cmd_t;

    typedef struct packed {
        logic [1:0] op;
        logic       full;
        logic       empty;
        logic       pos_root;
        logic       parent_gt;
        logic       srch_end;
        logic       srch_hit;
        logic       rm_was_last;
        logic       has_left;
        logic       has_right;
        logic       dn_swap_needed;
    } stat_t;
endpackage

### src/mhpq_ctrl.sv
// controller state machine for the heap priority queue
module mhpq_ctrl
    import mhpq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  stat_t  st,
    output cmd_t   cmd,
    output logic   busy,
    output logic   done
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DONE;
                    case (st.op)
                        OP_INSERT: state_next = S_INS_WR;
                        OP_REMOVE: state_next = S_SRCH_RD;
                        OP_QUERY:  state_next = S_Q_RD;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_INS_WR:    state_next = st.full ? S_DONE : S_UP_RDP;
            S_UP_RDP:    state_next = st.pos_root ? S_DONE : S_UP_WAIT;
            S_UP_WAIT:   state_next = S_UP_CMP;
            S_UP_CMP:    state_next = st.parent_gt ? S_UP_RDP : S_DONE;
            S_SRCH_RD:   state_next = st.srch_end ? S_DONE : S_SRCH_WAIT;
            S_SRCH_WAIT: state_next = S_SRCH_CMP;
            S_SRCH_CMP:  state_next = st.srch_hit ? S_RM_RDL : S_SRCH_RD;
            S_RM_RDL:    state_next = S_RM_WAITL;
            S_RM_WAITL:  state_next = S_RM_WR;
            S_RM_WR:     state_next = st.rm_was_last ? S_DONE : S_DN_RDL;
            S_DN_RDL:    state_next = st.has_left ? S_DN_RDR : S_UP_RDP;
            S_DN_RDR:    state_next = S_DN_WAIT;
            S_DN_WAIT:   state_next = S_DN_CMP;
            S_DN_CMP:    state_next = st.dn_swap_needed ? S_DN_RDL : S_UP_RDP;
            S_Q_RD:      state_next = st.empty ? S_DONE : S_Q_WAIT;
            S_Q_WAIT:    state_next = S_DONE;
            S_DONE:      state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != S_IDLE);
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = start;
                cmd.srch_clear = start;
                cmd.set_result = start;
                cmd.result_status = ST_OK;
            end
            S_INS_WR:
            begin
                if (st.full)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_FULL;
                end
                else
                begin
                    cmd.ins_write = 1'b1;
                end
            end
            S_UP_RDP:    cmd.up_rd_parent = !st.pos_root;
            S_UP_CMP:    cmd.up_swap = st.parent_gt;
            S_SRCH_RD:
            begin
                if (st.srch_end)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_NOTFOUND;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                end
            end
            S_SRCH_CMP:  cmd.srch_next = !st.srch_hit;
            S_RM_RDL:    cmd.rm_rd_last = 1'b1;
            S_RM_WR:     cmd.rm_write = 1'b1;
            S_DN_RDL:    cmd.dn_rd_left = st.has_left;
            S_DN_RDR:    cmd.dn_rd_right = 1'b1;
            S_DN_WAIT:   cmd.dn_latch_right = 1'b1;
            S_DN_CMP:    cmd.dn_swap = st.dn_swap_needed;
            S_Q_RD:
            begin
                cmd.q_rd = 1'b1;
                if (st.empty)
                begin
                    cmd.set_result = 1'b1;
                    cmd.result_status = ST_EMPTY;
                    cmd.result_empty = 1'b1;
                end
            end
            S_Q_WAIT:    cmd.result_min = 1'b1;
            S_DONE:      done = 1'b1;
            default:     done = 1'b0;
        endcase
    end
endmodule

### src/mhpq_datapath.sv
// datapath: heap memory, fill count, position and compare logic
module mhpq_datapath
    import mhpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value,
    input  cmd_t               cmd,
    output stat_t              st,
    output logic signed [31:0] min_value,
    output logic [1:0]         status
);
    logic signed [31:0] mem [CAPACITY];
    logic signed [31:0] rd_data_reg;
    logic        [AW-1:0] rd_addr;
    logic                 rd_en;
    logic                 wr_en_a;
    logic        [AW-1:0] wr_addr_a;
    logic signed [31:0]   wr_data_a;

    logic [CW-1:0]        count_reg, count_next;
    logic [AW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic signed [31:0]   key_reg, key_next;
    logic signed [31:0]   cur_reg, cur_next;
    logic signed [31:0]   left_reg, left_next;
    logic signed [31:0]   min_value_reg, min_value_next;
    logic [1:0]           status_reg, status_next;
    logic [CW-1:0]        left_idx, right_idx;
    logic [AW-1:0]        parent_idx;
    logic [CW-1:0]        last_idx;
    logic                 right_valid_reg;
    logic                 pick_right;
    logic signed [31:0]   best_val;

    // the key is written to its new slot in the cycle after the swap, through a pending write
    logic                 pend_reg, pend_next;
    logic [AW-1:0]        pend_addr_reg, pend_addr_next;

    // the key being sifted sits in cur_reg; memory slot at pos_reg is stale
    assign parent_idx = AW'((pos_reg - 1'b1) >> 1);
    assign left_idx   = {pos_reg, 1'b1};
    assign right_idx  = CW'({pos_reg, 1'b1}) + 1'b1;
    assign last_idx   = count_reg - 1'b1;

    assign pick_right = right_valid_reg && (rd_data_reg < left_reg);
    assign best_val   = pick_right ? rd_data_reg : left_reg;

    always_comb
    begin
        st = '0;
        st.op             = operation;
        st.full           = (count_reg == CW'(CAPACITY));
        st.empty          = (count_reg == '0);
        st.pos_root       = (pos_reg == '0);
        st.parent_gt      = (rd_data_reg > cur_reg);
        st.srch_end       = (idx_reg >= count_reg);
        st.srch_hit       = (rd_data_reg == key_reg);
        st.rm_was_last    = (idx_reg == count_reg);
        st.has_left       = (left_idx < count_reg);
        st.has_right      = (right_idx < count_reg);
        st.dn_swap_needed = (best_val < cur_reg);
    end

    // memory read mux
    always_comb
    begin
        rd_en = 1'b1;
        rd_addr = pos_reg;
        if (cmd.up_rd_parent)
        begin
            rd_addr = parent_idx;
        end
        else if (cmd.srch_rd)
        begin
            rd_addr = AW'(idx_reg);
        end
        else if (cmd.rm_rd_last)
        begin
            rd_addr = AW'(last_idx);
        end
        else if (cmd.dn_rd_left)
        begin
            rd_addr = AW'(left_idx);
        end
        else if (cmd.dn_rd_right)
        begin
            rd_addr = AW'(right_idx);
        end
        else if (cmd.q_rd)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_en = 1'b0;
        end
    end

    // one write port: placement, swap shift, removal fill or pending key write
    always_comb
    begin
        wr_en_a = 1'b0;
        wr_addr_a = pos_reg;
        wr_data_a = cur_reg;
        if (cmd.ins_write)
        begin
            wr_en_a = 1'b1;
            wr_addr_a = AW'(count_reg);
            wr_data_a = key_reg;
        end
        else if (cmd.up_swap)
        begin
            // parent moves down into pos, key goes to parent
            wr_en_a = 1'b1;
            wr_addr_a = pos_reg;
            wr_data_a = rd_data_reg;
        end
        else if (cmd.dn_swap)
        begin
            wr_en_a = 1'b1;
            wr_addr_a = pos_reg;
            wr_data_a = best_val;
        end
        else if (cmd.rm_write)
        begin
            wr_en_a = 1'b1;
            wr_addr_a = AW'(idx_reg);
            wr_data_a = rd_data_reg;
        end
        else if (pend_reg)
        begin
            // key lands in the slot it moved to on the previous swap
            wr_en_a = 1'b1;
            wr_addr_a = pend_addr_reg;
            wr_data_a = cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en_a)
        begin
            mem[wr_addr_a] <= wr_data_a;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        count_next      = count_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        cur_next        = cur_reg;
        left_next       = left_reg;
        min_value_next  = min_value_reg;
        status_next     = status_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        if (cmd.load_in)
        begin
            key_next = value;
        end
        if (cmd.srch_clear)
        begin
            idx_next = '0;
        end
        if (cmd.ins_write)
        begin
            count_next = count_reg + 1'b1;
            pos_next = AW'(count_reg);
            cur_next = key_reg;
        end
        if (cmd.up_swap)
        begin
            pos_next = parent_idx;
            pend_next = 1'b1;
            pend_addr_next = parent_idx;
        end
        if (cmd.srch_next)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.rm_rd_last)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.rm_write)
        begin
            pos_next = AW'(idx_reg);
            cur_next = rd_data_reg;
        end
        if (cmd.dn_rd_right)
        begin
            left_next = rd_data_reg;
        end
        if (cmd.dn_swap)
        begin
            pos_next = pick_right ? AW'(right_idx) : AW'(left_idx);
            pend_next = 1'b1;
            pend_addr_next = pick_right ? AW'(right_idx) : AW'(left_idx);
        end
        if (cmd.set_result)
        begin
            status_next = cmd.result_status;
            min_value_next = cmd.result_empty ? -32'sd1 : 32'sd0;
        end
        if (cmd.result_min)
        begin
            min_value_next = rd_data_reg;
            status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        idx_reg         <= idx_next;
        key_reg         <= key_next;
        cur_reg         <= cur_next;
        left_reg        <= left_next;
        min_value_reg   <= min_value_next;
        status_reg      <= status_next;
        pend_addr_reg   <= pend_addr_next;
        right_valid_reg <= cmd.dn_rd_right ? (right_idx < count_reg) : right_valid_reg;
    end

    assign min_value = min_value_reg;
    assign status    = status_reg;
endmodule

### src/min_heap_priority_queue_core.sv
// top level of the heap priority queue
// query reads the root; insert appends the key after the last entry and sifts it up;
// remove scans slot by slot, puts the last entry in the hit slot, sifts down then up
// one operation at a time: start is taken in the cycle after done, once busy is low
// reset clears the fill count and controller; memory contents need no clearing
// one result per operation, strobed by done for one cycle; the receiver cannot stall
module min_heap_priority_queue_core
    import mhpq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] min_value,
    output logic [1:0]         status
);
`include "min_heap_priority_queue_core_macros.svh"

    cmd_t  cmd;
    stat_t st;

    mhpq_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    mhpq_datapath u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .operation (operation),
        .value     (value),
        .cmd       (cmd),
        .st        (st),
        .min_value (min_value),
        .status    (status)
    );

    `MHPQ_ASSERT(a_done_ends_busy, done |=> !busy, "done not followed by idle")
    `MHPQ_NEVER(a_ins_full, cmd.ins_write && st.full, "insert written while full")
    `MHPQ_ASSERT(a_empty_query, (done && status == ST_EMPTY) |-> (min_value == -32'sd1),
        "empty query must return -1")
endmodule
